[rtl/core/lqs_pkg.sv]
package lqs_pkg;

    // Fixed widths of the command and result fields.
    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;

    // Command codes.
    typedef enum logic [1:0] {
        OP_STATUS = 2'd0,
        OP_ENQ    = 2'd1,
        OP_DEQ    = 2'd2,
        OP_SEARCH = 2'd3
    } opcode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_FRONT,
        S_SCAN
    } state_t;

    // One result as it leaves the block.
    typedef struct packed {
        status_t                    status;
        logic signed [DATA_W-1:0]   data_out;
        logic [IDX_W-1:0]           found_index;
        logic [CNT_W-1:0]           count;
        logic signed [DATA_W-1:0]   front_value;
        logic                       front_valid;
    } result_t;

endpackage

[rtl/core/lqs_ram.sv]
module lqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/linear_queue_with_search.sv]
// Linear (non-circular) queue of signed 32-bit words with a search command.
// A command is transferred when start is high and busy is low; it carries
// opcode (status, enqueue, dequeue, search) and data_in. Exactly one result
// follows for every command: done is high for one cycle and status,
// data_out, found_index, count, front_value and front_valid are valid in that
// cycle. The receiver cannot stall; done marks the result only in that cycle.
// Status, enqueue, a dequeue that empties the queue, and a dequeue or search
// on an empty queue register their result at the transfer, so done rises in
// the next cycle. A dequeue that leaves words behind reads the new front word
// from the slot memory and registers its result in state S_FRONT. A search
// reads one slot per cycle through the registered memory port from the front
// slot up and ends at the first matching held word or after the last one.
// busy is low again in the cycle that done rises, so a new command may be
// transferred while the previous result is shown.
// Reset clears both pointers, which makes the queue empty; the slot memory
// is not cleared because only written slots are ever read.
module linear_queue_with_search #(
    parameter int DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          opcode,
    input  logic signed [lqs_pkg::DATA_W-1:0]   data_in,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [lqs_pkg::DATA_W-1:0]   data_out,
    output logic [lqs_pkg::IDX_W-1:0]           found_index,
    output logic [lqs_pkg::CNT_W-1:0]           count,
    output logic signed [lqs_pkg::DATA_W-1:0]   front_value,
    output logic                                front_valid
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] FULL_POS = PW'(DEPTH);

    lqs_pkg::state_t                  state_reg, state_next;
    logic [PW-1:0]                    fp_reg, fp_next;
    logic [PW-1:0]                    wp_reg, wp_next;
    logic signed [lqs_pkg::DATA_W-1:0] front_reg, front_next;
    logic signed [lqs_pkg::DATA_W-1:0] key_reg, key_next;
    logic [PW-1:0]                    scan_reg, scan_next;
    logic [PW-1:0]                    cmp_idx_reg, cmp_idx_next;
    logic                             cmp_vld_reg, cmp_vld_next;
    logic                             done_reg, done_next;
    lqs_pkg::result_t                 res_reg, res_next;

    // Memory port signals.
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic                             ram_re;
    logic [AW-1:0]                    ram_raddr;
    logic [lqs_pkg::DATA_W-1:0]       ram_rdata;
    logic signed [lqs_pkg::DATA_W-1:0] rd_word;

    // Shared decisions.
    logic                             accept;
    logic                             empty;
    logic [PW-1:0]                    fp_inc;
    logic                             last_deq;
    logic                             hit;
    logic                             scan_done;

    // Finish bookkeeping.
    logic                             fin;
    lqs_pkg::status_t                 fin_status;
    logic signed [lqs_pkg::DATA_W-1:0] fin_dout;
    logic [PW-1:0]                    fin_idx;
    logic [PW-1:0]                    cnt_val;
    logic                             fvld;
    logic [PW+lqs_pkg::CNT_W-1:0]     cnt_ext;
    logic [PW+lqs_pkg::IDX_W-1:0]     idx_ext;

    lqs_ram #(
        .WIDTH(lqs_pkg::DATA_W),
        .DEPTH(DEPTH)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(data_in),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_word   = ram_rdata;
    assign accept    = start && (state_reg == lqs_pkg::S_IDLE);
    assign empty     = (fp_reg == wp_reg);
    assign fp_inc    = fp_reg + PW'(1);
    assign last_deq  = (fp_inc == wp_reg);
    assign hit       = cmp_vld_reg && (rd_word == key_reg);
    assign scan_done = (scan_reg == wp_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lqs_pkg::S_IDLE:
            begin
                if (accept && !empty)
                begin
                    if (opcode == lqs_pkg::OP_DEQ && !last_deq)
                    begin
                        state_next = lqs_pkg::S_FRONT;
                    end
                    else if (opcode == lqs_pkg::OP_SEARCH)
                    begin
                        state_next = lqs_pkg::S_SCAN;
                    end
                end
            end
            lqs_pkg::S_FRONT:
            begin
                state_next = lqs_pkg::S_IDLE;
            end
            lqs_pkg::S_SCAN:
            begin
                if (hit || scan_done)
                begin
                    state_next = lqs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lqs_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory accesses and result assembly.
    always_comb
    begin
        fp_next      = fp_reg;
        wp_next      = wp_reg;
        front_next   = front_reg;
        key_next     = key_reg;
        scan_next    = scan_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = wp_reg[AW-1:0];
        ram_re       = 1'b0;
        ram_raddr    = fp_inc[AW-1:0];
        fin          = 1'b0;
        fin_status   = lqs_pkg::ST_OK;
        fin_dout     = '0;
        fin_idx      = '0;

        case (state_reg)
            lqs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (lqs_pkg::opcode_t'(opcode))
                        lqs_pkg::OP_ENQ:
                        begin
                            fin = 1'b1;
                            if (wp_reg == FULL_POS)
                            begin
                                fin_status = lqs_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we  = 1'b1;
                                wp_next = wp_reg + PW'(1);
                                if (empty)
                                begin
                                    front_next = data_in;
                                end
                            end
                        end
                        lqs_pkg::OP_DEQ:
                        begin
                            if (empty)
                            begin
                                fin        = 1'b1;
                                fin_status = lqs_pkg::ST_EMPTY;
                            end
                            else if (last_deq)
                            begin
                                // The queue drains: both pointers go back to slot 0.
                                fin      = 1'b1;
                                fin_dout = front_reg;
                                fp_next  = '0;
                                wp_next  = '0;
                            end
                            else
                            begin
                                // Keep the outgoing word and fetch the new front.
                                key_next = front_reg;
                                fp_next  = fp_inc;
                                ram_re   = 1'b1;
                            end
                        end
                        lqs_pkg::OP_SEARCH:
                        begin
                            key_next  = data_in;
                            scan_next = fp_reg;
                            if (empty)
                            begin
                                fin        = 1'b1;
                                fin_status = lqs_pkg::ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            lqs_pkg::S_FRONT:
            begin
                front_next = rd_word;
                fin        = 1'b1;
                fin_dout   = key_reg;
            end
            lqs_pkg::S_SCAN:
            begin
                // Issue one read per cycle and compare the word read last cycle.
                ram_raddr = scan_reg[AW-1:0];
                if (hit)
                begin
                    fin     = 1'b1;
                    fin_idx = cmp_idx_reg;
                end
                else if (!scan_done)
                begin
                    ram_re       = 1'b1;
                    cmp_idx_next = scan_reg;
                    cmp_vld_next = 1'b1;
                    scan_next    = scan_reg + PW'(1);
                end
                else
                begin
                    fin        = 1'b1;
                    fin_status = lqs_pkg::ST_NOTFOUND;
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase

        // Count and peek reflect the pointers after the command.
        cnt_val = wp_next - fp_next;
        fvld    = (wp_next != fp_next);
        cnt_ext = {{lqs_pkg::CNT_W{1'b0}}, cnt_val};
        idx_ext = {{lqs_pkg::IDX_W{1'b0}}, fin_idx};

        done_next = fin;
        res_next  = res_reg;
        if (fin)
        begin
            res_next.status      = fin_status;
            res_next.data_out    = fin_dout;
            res_next.found_index = idx_ext[lqs_pkg::IDX_W-1:0];
            res_next.count       = cnt_ext[lqs_pkg::CNT_W-1:0];
            res_next.front_value = fvld ? front_next : '0;
            res_next.front_valid = fvld;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lqs_pkg::S_IDLE;
            fp_reg      <= '0;
            wp_reg      <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fp_reg      <= fp_next;
            wp_reg      <= wp_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        front_reg   <= front_next;
        key_reg     <= key_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    assign busy        = (state_reg != lqs_pkg::S_IDLE);
    assign done        = done_reg;
    assign status      = res_reg.status;
    assign data_out    = res_reg.data_out;
    assign found_index = res_reg.found_index;
    assign count       = res_reg.count;
    assign front_value = res_reg.front_value;
    assign front_valid = res_reg.front_valid;

endmodule

[tb/linear_queue_with_search_test.sv]
// Keeps a software copy of the queue. It predicts one result for every
// transferred command and compares each result strobed by the block with
// the oldest prediction.
class queue_scoreboard;

    localparam int SLOTS = 64;

    logic [lqs_pkg::DATA_W-1:0] slots [SLOTS];
    int unsigned                front_pos;
    int unsigned                write_pos;
    lqs_pkg::result_t           expected_results [$];

    int mismatches;
    int checked;
    int overflows;
    int empty_dequeues;
    int search_hits;
    int search_misses;
    int max_count;

    function new();
        front_pos = 0;
        write_pos = 0;
        mismatches = 0;
        checked = 0;
        overflows = 0;
        empty_dequeues = 0;
        search_hits = 0;
        search_misses = 0;
        max_count = 0;
    endfunction

    // Applies one transferred command to the copy and queues its result.
    function void note_command(lqs_pkg::opcode_t op, logic [lqs_pkg::DATA_W-1:0] value);
        lqs_pkg::result_t r;
        int unsigned      i;
        bit               hit;
        r = '0;
        r.status = lqs_pkg::ST_OK;
        hit = 1'b0;
        case (op)
            lqs_pkg::OP_ENQ:
            begin
                if (write_pos >= SLOTS)
                begin
                    r.status = lqs_pkg::ST_OVERFLOW;
                    overflows++;
                end
                else
                begin
                    slots[write_pos] = value;
                    write_pos++;
                end
            end
            lqs_pkg::OP_DEQ:
            begin
                if (front_pos >= write_pos)
                begin
                    r.status = lqs_pkg::ST_EMPTY;
                    empty_dequeues++;
                end
                else
                begin
                    r.data_out = slots[front_pos];
                    front_pos++;
                    // The last word left, so both pointers return to slot 0.
                    if (front_pos >= write_pos)
                    begin
                        front_pos = 0;
                        write_pos = 0;
                    end
                end
            end
            lqs_pkg::OP_SEARCH:
            begin
                r.status = lqs_pkg::ST_NOTFOUND;
                for (i = front_pos; i < write_pos && !hit; i++)
                begin
                    if (slots[i] == value)
                    begin
                        hit = 1'b1;
                        r.status = lqs_pkg::ST_OK;
                        r.found_index = i[lqs_pkg::IDX_W-1:0];
                    end
                end
                if (hit)
                    search_hits++;
                else
                    search_misses++;
            end
            default:
            begin
            end
        endcase

        // Peek fields reflect the queue after the command.
        if (front_pos < write_pos)
        begin
            r.count = lqs_pkg::CNT_W'(write_pos - front_pos);
            r.front_value = slots[front_pos];
            r.front_valid = 1'b1;
            if (write_pos - front_pos > max_count)
                max_count = write_pos - front_pos;
        end
        expected_results.push_back(r);
    endfunction

    // Compares one strobed result with the oldest prediction.
    function void check_result(lqs_pkg::result_t actual);
        lqs_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with no command pending: st=%0d dout=%0d",
                         actual.status, actual.data_out);
            return;
        end
        want = expected_results.pop_front();
        checked++;
        if (actual !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("ERROR: result %0d differs", checked);
                $display("  expected st=%0d dout=%0d idx=%0d cnt=%0d front=%0d fv=%0d",
                         want.status, want.data_out, want.found_index, want.count,
                         want.front_value, want.front_valid);
                $display("  actual   st=%0d dout=%0d idx=%0d cnt=%0d front=%0d fv=%0d",
                         actual.status, actual.data_out, actual.found_index, actual.count,
                         actual.front_value, actual.front_valid);
            end
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // Returns a word currently held, or a random word when the queue is empty.
    function logic [lqs_pkg::DATA_W-1:0] held_value();
        if (write_pos > front_pos)
            return slots[$urandom_range(write_pos - 1, front_pos)];
        return $urandom();
    endfunction

    function bit full_array();
        return write_pos >= SLOTS;
    endfunction

    // Results still owed at the end count as failures.
    function int failures();
        if (expected_results.size() != 0)
            $display("ERROR: %0d results never arrived", expected_results.size());
        return mismatches + expected_results.size();
    endfunction

endclass

module linear_queue_with_search_test;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [1:0]                         opcode;
    logic signed [lqs_pkg::DATA_W-1:0]  data_in;
    logic                               done;
    logic [1:0]                         status;
    logic signed [lqs_pkg::DATA_W-1:0]  data_out;
    logic [lqs_pkg::IDX_W-1:0]          found_index;
    logic [lqs_pkg::CNT_W-1:0]          count;
    logic signed [lqs_pkg::DATA_W-1:0]  front_value;
    logic                               front_valid;

    queue_scoreboard sb;
    int              issued;
    int              cycle_count;

    linear_queue_with_search #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .data_in(data_in),
        .done(done),
        .status(status),
        .data_out(data_out),
        .found_index(found_index),
        .count(count),
        .front_value(front_value),
        .front_valid(front_valid)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Result monitor: done marks a result valid for exactly one cycle.
    always @(posedge clk)
    begin
        lqs_pkg::result_t r;
        if (rst_n && done)
        begin
            r.status = lqs_pkg::status_t'(status);
            r.data_out = data_out;
            r.found_index = found_index;
            r.count = count;
            r.front_value = front_value;
            r.front_valid = front_valid;
            sb.check_result(r);
        end
    end

    // Presents a command and holds it until a transfer takes place.
    task automatic send_command(input lqs_pkg::opcode_t op,
                                input logic [lqs_pkg::DATA_W-1:0] value);
        @(negedge clk);
        start <= 1'b1;
        opcode <= op;
        data_in <= value;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sb.note_command(op, value);
        issued++;
    endtask

    // Idle cycles with start low and random junk on the payload.
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
            opcode <= 2'($urandom_range(3));
            data_in <= $urandom();
        end
    endtask

    // Extremes, a small pool that produces duplicates, and random words.
    function automatic logic [lqs_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3, 4, 5: return $urandom_range(7);
            default: return $urandom();
        endcase
    endfunction

    function automatic lqs_pkg::opcode_t pick_opcode(traffic_mode_t mode);
        int roll;
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL:
                return (roll < 70) ? lqs_pkg::OP_ENQ :
                       (roll < 80) ? lqs_pkg::OP_DEQ :
                       (roll < 95) ? lqs_pkg::OP_SEARCH : lqs_pkg::OP_STATUS;
            MODE_DRAIN:
                return (roll < 15) ? lqs_pkg::OP_ENQ :
                       (roll < 70) ? lqs_pkg::OP_DEQ :
                       (roll < 92) ? lqs_pkg::OP_SEARCH : lqs_pkg::OP_STATUS;
            default:
                return (roll < 35) ? lqs_pkg::OP_ENQ :
                       (roll < 65) ? lqs_pkg::OP_DEQ :
                       (roll < 90) ? lqs_pkg::OP_SEARCH : lqs_pkg::OP_STATUS;
        endcase
    endfunction

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ERROR: run limit of %0d cycles reached", CYCLE_LIMIT);
        $display("** linear_queue_with_search: FAILED **");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        traffic_mode_t              mode;
        int                         episode_len;
        int                         burst_left;
        lqs_pkg::opcode_t           op;
        logic [lqs_pkg::DATA_W-1:0] value;

        sb = new();
        issued = 0;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = lqs_pkg::OP_STATUS;
        data_in = '0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty-queue cases, extreme words, first match among
        // duplicates, searches that skip freed slots, and the pointer reset.
        send_command(lqs_pkg::OP_STATUS, 32'h0);
        send_command(lqs_pkg::OP_DEQ, 32'h0);
        send_command(lqs_pkg::OP_SEARCH, 32'h0);
        send_command(lqs_pkg::OP_ENQ, 32'h7FFF_FFFF);
        send_command(lqs_pkg::OP_ENQ, 32'h8000_0000);
        send_command(lqs_pkg::OP_ENQ, 32'h0);
        send_command(lqs_pkg::OP_ENQ, 32'hFFFF_FFFF);
        send_command(lqs_pkg::OP_ENQ, 32'h8000_0000);
        send_command(lqs_pkg::OP_SEARCH, 32'h8000_0000);
        send_command(lqs_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_command(lqs_pkg::OP_SEARCH, 32'd12345);
        send_command(lqs_pkg::OP_STATUS, 32'hFFFF_FFFF);
        send_command(lqs_pkg::OP_DEQ, 32'h0);
        send_command(lqs_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        send_command(lqs_pkg::OP_DEQ, 32'h0);
        send_command(lqs_pkg::OP_SEARCH, 32'h8000_0000);
        send_command(lqs_pkg::OP_DEQ, 32'h0);
        send_command(lqs_pkg::OP_DEQ, 32'h0);
        send_command(lqs_pkg::OP_DEQ, 32'h0);
        send_command(lqs_pkg::OP_DEQ, 32'h0);
        send_command(lqs_pkg::OP_STATUS, 32'h0);
        send_command(lqs_pkg::OP_ENQ, 32'h5555_5555);
        send_command(lqs_pkg::OP_ENQ, 32'hAAAA_AAAA);
        send_command(lqs_pkg::OP_SEARCH, 32'hAAAA_AAAA);

        // Random part in episodes that fill, drain or mix, sent in bursts.
        burst_left = 0;
        while (issued < RANDOM_ITEMS + 24)
        begin
            mode = traffic_mode_t'($urandom_range(2));
            episode_len = $urandom_range(120, 20);
            repeat (episode_len)
            begin
                op = pick_opcode(mode);
                // On a full array, keep probing overflow now and then.
                if (sb.full_array() && $urandom_range(3) == 0)
                    op = lqs_pkg::OP_ENQ;
                if (op == lqs_pkg::OP_SEARCH && $urandom_range(99) < 60)
                    value = sb.held_value();
                else
                    value = pick_value();
                send_command(op, value);
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(40, 1);
                    if ($urandom_range(9) >= 3)
                        idle_cycles($urandom_range(6, 1));
                end
                else
                begin
                    burst_left--;
                end
            end
        end

        // Drain the results, then keep the clock running so any stray result is checked.
        idle_cycles(1);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DEPTH + 4)
            @(negedge clk);

        $display("Ran %0d commands, %0d results checked, up to %0d words held.",
                 issued, sb.checked, sb.max_count);
        $display("Saw %0d overflows, %0d empty dequeues, %0d search hits, %0d misses.",
                 sb.overflows, sb.empty_dequeues, sb.search_hits, sb.search_misses);
        if (sb.failures() == 0)
            $display("** linear_queue_with_search: PASSED **");
        else
            $display("** linear_queue_with_search: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/lqs_pkg.sv
rtl/core/lqs_ram.sv
rtl/core/linear_queue_with_search.sv
tb/linear_queue_with_search_test.sv
